### rtl/hse_pkg.sv
// Package for the heap sort engine: widths, capacity default, FSM state,
// cell control and cell link types.
// No dependencies.
`default_nettype none

package hse_pkg;

  localparam int HSE_DATA_W   = 32;
  localparam int HSE_CAPACITY = 64;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } hse_state_e;

  // Command broadcast to every cell in the row.
  typedef struct packed {
    logic ins;    // insert new value in sorted position
    logic shift;  // shift row one place toward cell 0
  } hse_ctrl_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic                         valid;
    logic                         less;   // new value sorts before this cell's value
    logic signed [HSE_DATA_W-1:0] value;
  } hse_link_t;

endpackage

`default_nettype wire

### rtl/hse_cell.sv
// One sorting cell: holds one element, inserts or shifts with its neighbors.
// Depends on hse_pkg.
`default_nettype none

module hse_cell
  import hse_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hse_ctrl_t                    ctrl_i,
  input  logic signed [HSE_DATA_W-1:0] new_value_i,
  input  hse_link_t                    prev_i,
  input  hse_link_t                    next_i,
  output hse_link_t                    link_o
);

  logic                         valid_q, valid_d;
  logic signed [HSE_DATA_W-1:0] value_q, value_d;
  logic                         less;

  // Empty cells act as +infinity.
  assign less = !valid_q || (new_value_i < value_q);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.shift) begin
      valid_d = next_i.valid;
      value_d = next_i.value;
    end else if (ctrl_i.ins && less) begin
      if (prev_i.less) begin
        // left neighbor is pushed right into this cell
        valid_d = prev_i.valid;
        value_d = prev_i.value;
      end else begin
        valid_d = 1'b1;
        value_d = new_value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.less  = less;
  assign link_o.value = value_q;

endmodule

`default_nettype wire

### rtl/heap_sort_engine.sv
// Top level of the sort engine: load/drain controller, output register and
// the row of sorting cells. Depends on hse_pkg and hse_cell.
//
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------------
//  input   | in_valid_i / in_ready_o   | value_i, last_in_i
//  output  | out_valid_o / out_ready_i | sorted_value_o, last_out_o, overflow_o
//
// Load: one input transaction per cycle while loading; each element is inserted
// into the cell row in sorted order in the cycle it is accepted (one signed
// compare per cell). The transaction with last_in_i ends the set; the row then
// drains one element per cycle from cell 0 into the output register, smallest
// first, whenever that register is empty or out_ready_i is high.
// in_ready_o is low while draining; the output register lets the next load
// start while the final result still waits. Elements beyond CAPACITY are
// dropped and flag overflow_o on every result of that set.
// Reset clears all cell valid bits, the count and the drop flag at once.
`default_nettype none

module heap_sort_engine
  import hse_pkg::*;
#(
  parameter int CAPACITY = HSE_CAPACITY
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [HSE_DATA_W-1:0] value_i,
  input  logic                         last_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [HSE_DATA_W-1:0] sorted_value_o,
  output logic                         last_out_o,
  output logic                         overflow_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  hse_state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;   // held elements, then remaining to emit
  logic dropped_q, dropped_d;
  logic out_valid_q, out_valid_d;
  logic signed [HSE_DATA_W-1:0] out_value_q, out_value_d;
  logic out_last_q, out_last_d, out_ovf_q, out_ovf_d;

  hse_ctrl_t ctrl;
  hse_link_t links [CAPACITY];
  hse_link_t edge_lo, edge_hi;

  logic in_acc, has_room, load_out;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;
  assign has_room   = count_q < CNT_W'(CAPACITY);
  assign load_out   = (state_q == ST_DRAIN) && (!out_valid_q || out_ready_i);

  assign ctrl.ins   = in_acc && has_room;
  assign ctrl.shift = load_out;

  // Boundaries: nothing pushes into cell 0; the far end shifts in empties.
  assign edge_lo = '{valid: 1'b1, less: 1'b0, value: '0};
  assign edge_hi = '{valid: 1'b0, less: 1'b0, value: '0};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            count_d = count_q + CNT_W'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (last_in_i) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          out_value_d = links[0].value;
          out_last_d  = (count_q == CNT_W'(1));
          out_ovf_d   = dropped_q;
          count_d     = count_q - CNT_W'(1);
          if (count_q == CNT_W'(1)) begin
            // set done: ready for the next one
            state_d   = ST_LOAD;
            dropped_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign last_out_o     = out_last_q;
  assign overflow_o     = out_ovf_q;

  // Cell row: cell 0 holds the smallest element.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    hse_link_t prev_l, next_l;
    if (i == 0) begin : g_lo
      assign prev_l = edge_lo;
    end else begin : g_mid_lo
      assign prev_l = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign next_l = edge_hi;
    end else begin : g_mid_hi
      assign next_l = links[i+1];
    end
    hse_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_value_i (value_i),
      .prev_i      (prev_l),
      .next_i      (next_l),
      .link_o      (links[i])
    );
  end

  // Draining always has something left in the row.
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> ((count_q != '0) && links[0].valid))
    else $error("drain with empty row");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

  // Row stays sorted between the first two cells.
  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (links[0].valid && links[1].valid) |-> (links[0].value <= links[1].value))
    else $error("cell row out of order");

  // A final result returns the engine to loading.
  a_last_ends_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && (count_q == CNT_W'(1))) |=> (in_ready_o && out_last_q))
    else $error("set end not handled");

endmodule

`default_nettype wire
